FILE: hdl/txcm_pkg.sv
// Package for the transmit slot and byte credit manager.
// Shared types, result and op codes, register reset values. No dependencies.
`default_nettype none

package txcm_pkg;

   // Default number of packet slots
   localparam int SLOTS_DEF = 32;

   // Field widths fixed by the transaction format
   localparam int TOTAL_W  = 13;   // roundup4(frame + header) <= 4352
   localparam int SLOT_W   = 12;   // slot part of a cookie
   localparam int BYTES_W  = 16;
   localparam int ADDR_W   = 4;    // three 32-bit registers at 0, 4, 8
   localparam int DATA_W   = 32;

   localparam logic [BYTES_W-1:0] LOW_ROOM_BYTES = 16'd12;

   // Register reset values
   localparam logic [15:0] BUFFER_BYTES_RST = 16'd1920;
   localparam logic [7:0]  HEADER_BYTES_RST = 8'd104;
   localparam logic [3:0]  QUEUE_NUMBER_RST = 4'd1;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_BUFFER_BYTES = 2'd0;
   localparam logic [1:0] REG_HEADER_BYTES = 2'd1;
   localparam logic [1:0] REG_QUEUE_NUMBER = 2'd2;

   // Transaction op codes
   localparam logic OP_TX_REQ    = 1'b0;
   localparam logic OP_TX_STATUS = 1'b1;

   typedef enum logic [2:0] {
      RC_OK         = 3'd0,
      RC_TOO_LONG   = 3'd1,
      RC_NO_SLOT    = 3'd2,
      RC_NO_ROOM    = 3'd3,
      RC_BAD_COOKIE = 3'd4
   } result_code_type;

   typedef struct packed {
      logic [15:0] buffer_bytes;
      logic [7:0]  header_bytes;
      logic [3:0]  queue_number;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_INIT = 2'd0,
      ST_IDLE = 2'd1,
      ST_EXEC = 2'd2
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic init_step;   // clear one stack/busy entry
      logic load;        // latch transaction, read memories
      logic commit;      // update state, register result
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic init_last;   // clearing pass at the last entry
   } dp_status_type;

endpackage

`default_nettype wire

FILE: hdl/txcm_csr.sv
// Configuration register file of the transmit slot and byte credit manager.
// APB-style write/read access; depends on txcm_pkg.
`default_nettype none

module txcm_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [txcm_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [txcm_pkg::DATA_W-1:0]   pwdata,
   output logic      [txcm_pkg::DATA_W-1:0]   prdata,
   output logic                               pready,
   output txcm_pkg::cfg_type                  cfg
);
   import txcm_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_bytes <= BUFFER_BYTES_RST;
         cfg_ff.header_bytes <= HEADER_BYTES_RST;
         cfg_ff.queue_number <= QUEUE_NUMBER_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_BUFFER_BYTES: cfg_ff.buffer_bytes <= pwdata[15:0];
            REG_HEADER_BYTES: cfg_ff.header_bytes <= pwdata[7:0];
            REG_QUEUE_NUMBER: cfg_ff.queue_number <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BUFFER_BYTES: prdata = {16'd0, cfg_ff.buffer_bytes};
         REG_HEADER_BYTES: prdata = {24'd0, cfg_ff.header_bytes};
         REG_QUEUE_NUMBER: prdata = {28'd0, cfg_ff.queue_number};
         default:          prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/txcm_ctrl.sv
// Controller of the transmit slot and byte credit manager: clearing pass,
// idle and execute states. Depends on txcm_pkg.
`default_nettype none

module txcm_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire txcm_pkg::dp_status_type status,
   output txcm_pkg::ctrl_cmd_type       cmd,
   output logic                         busy
);
   import txcm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
         end
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_EXEC: begin
            cmd.commit = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/txcm_dpath.sv
// Datapath of the transmit slot and byte credit manager: free slot stack,
// per-slot byte and busy memories, credit arithmetic, result registers.
// Depends on txcm_pkg.
`default_nettype none

module txcm_dpath #(
   parameter int SLOTS = txcm_pkg::SLOTS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire txcm_pkg::ctrl_cmd_type cmd,
   output txcm_pkg::dp_status_type     status,
   input  wire txcm_pkg::cfg_type      cfg,
   input  wire logic                   req_op,
   input  wire logic [11:0]            req_frame_length,
   input  wire logic [15:0]            req_status_cookie,
   output logic                        rsp_strobe,
   output logic [2:0]                  rsp_result_code,
   output logic [15:0]                 rsp_cookie_out,
   output logic                        rsp_queue_stopped,
   output logic [5:0]                  rsp_free_slot_count,
   output logic [15:0]                 rsp_bytes_in_use_out
);
   import txcm_pkg::*;

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNTW = $clog2(SLOTS + 1);

   // Memories
   logic [IDXW-1:0]    free_stack_mem [SLOTS];
   logic [TOTAL_W-1:0] slot_bytes_mem [SLOTS];
   logic               slot_busy_mem  [SLOTS];

   // Control state
   logic [CNTW-1:0]    count_ff, count_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic               stopped_ff, stopped_in;
   logic [IDXW-1:0]    init_idx_ff;
   logic               strobe_ff;

   // Transaction stage
   logic               op_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [BYTES_W-1:0] room_ff;
   logic [IDXW-1:0]    rd_slot_ff;
   logic [TOTAL_W-1:0] rd_bytes_ff;
   logic               rd_busy_ff;

   // Result registers
   result_code_type    code_ff, code_in;
   logic [15:0]        cookie_ff, cookie_in;

   logic [TOTAL_W-1:0] total_calc;
   logic [BYTES_W-1:0] room_calc;
   logic [BYTES_W-1:0] total_ext, rd_bytes_ext, room_after;
   logic [IDXW-1:0]    pop_addr, rel_addr;

   logic               busy_we, busy_wd;
   logic [IDXW-1:0]    busy_wa;
   logic               bytes_we;
   logic               free_we;

   // Accept cycle: size rounding, room left, memory addresses
   assign total_calc = (TOTAL_W'(req_frame_length) + TOTAL_W'(cfg.header_bytes)
                        + TOTAL_W'(3)) & ~TOTAL_W'(3);
   assign room_calc  = (bytes_ff > cfg.buffer_bytes) ? '0
                                                     : cfg.buffer_bytes - bytes_ff;
   assign pop_addr   = IDXW'(count_ff - 1'b1);
   assign rel_addr   = req_status_cookie[IDXW-1:0];

   assign total_ext    = BYTES_W'(total_ff);
   assign rd_bytes_ext = BYTES_W'(rd_bytes_ff);
   assign room_after   = room_ff - total_ext;

   assign status.init_last = (init_idx_ff == IDXW'(SLOTS - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_op;
         total_ff    <= total_calc;
         slot_ff     <= req_status_cookie[SLOT_W-1:0];
         room_ff     <= room_calc;
         rd_slot_ff  <= free_stack_mem[pop_addr];
         rd_bytes_ff <= slot_bytes_mem[rel_addr];
         rd_busy_ff  <= slot_busy_mem[rel_addr];
      end
   end

   // Execute cycle
   always_comb begin
      code_in    = RC_OK;
      cookie_in  = '0;
      count_in   = count_ff;
      bytes_in   = bytes_ff;
      stopped_in = stopped_ff;
      busy_we    = 1'b0;
      busy_wa    = rd_slot_ff;
      busy_wd    = 1'b0;
      bytes_we   = 1'b0;
      free_we    = 1'b0;
      if (cmd.commit) begin
         if (op_ff == OP_TX_REQ) begin
            if (total_ext > cfg.buffer_bytes) begin
               code_in = RC_TOO_LONG;
            end else if (count_ff == '0) begin
               code_in = RC_NO_SLOT;
            end else if (total_ext > room_ff) begin
               code_in    = RC_NO_ROOM;
               stopped_in = 1'b1;
            end else begin
               count_in  = count_ff - 1'b1;
               bytes_in  = bytes_ff + total_ext;
               cookie_in = {cfg.queue_number + 4'd1, SLOT_W'(rd_slot_ff)};
               busy_we   = 1'b1;
               busy_wd   = 1'b1;
               bytes_we  = 1'b1;
               if (room_after < LOW_ROOM_BYTES || count_in == '0) stopped_in = 1'b1;
            end
         end else begin
            if (slot_ff >= SLOT_W'(SLOTS) || !rd_busy_ff || count_ff >= CNTW'(SLOTS)) begin
               code_in = RC_BAD_COOKIE;
            end else begin
               bytes_in   = (bytes_ff > rd_bytes_ext) ? bytes_ff - rd_bytes_ext : '0;
               count_in   = count_ff + 1'b1;
               stopped_in = 1'b0;
               busy_we    = 1'b1;
               busy_wa    = slot_ff[IDXW-1:0];
               free_we    = 1'b1;
            end
         end
      end
   end

   // Memory writes; the clearing pass owns the stack and busy write ports after reset
   always_ff @(posedge clock) begin
      if (cmd.init_step) begin
         free_stack_mem[init_idx_ff] <= init_idx_ff;
         slot_busy_mem[init_idx_ff]  <= 1'b0;
      end else begin
         if (free_we) free_stack_mem[IDXW'(count_ff)] <= slot_ff[IDXW-1:0];
         if (busy_we) slot_busy_mem[busy_wa] <= busy_wd;
      end
      if (bytes_we) slot_bytes_mem[rd_slot_ff] <= total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= CNTW'(SLOTS);
         bytes_ff    <= '0;
         stopped_ff  <= 1'b0;
         init_idx_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         strobe_ff <= cmd.commit;
         if (cmd.init_step) init_idx_ff <= init_idx_ff + 1'b1;
         if (cmd.commit) begin
            count_ff   <= count_in;
            bytes_ff   <= bytes_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         code_ff   <= code_in;
         cookie_ff <= cookie_in;
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_result_code      = code_ff;
   assign rsp_cookie_out       = cookie_ff;
   assign rsp_queue_stopped    = stopped_ff;
   assign rsp_free_slot_count  = 6'(count_ff);
   assign rsp_bytes_in_use_out = bytes_ff;

endmodule

`default_nettype wire

FILE: hdl/tx_slot_and_byte_credit_manager_unit.sv
// Result: an accepted transaction is latched, executed, then registered onto
//   the rsp_ ports with rsp_strobe high. Busy is high in the execute state,
//   so each transaction ends before the next is taken; the free stack and
//   per-slot memories take one registered read and one write each.
// Reset: synchronous, active high; a clearing pass then rebuilds the free
//   stack and busy marks, with busy high throughout.
`default_nettype none

module tx_slot_and_byte_credit_manager_unit #(
   parameter int SLOTS = txcm_pkg::SLOTS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Command channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_op,
   input  wire logic [11:0]                   req_frame_length,
   input  wire logic [15:0]                   req_status_cookie,
   // Result channel, one strobe per transaction, no backpressure
   output logic                               rsp_strobe,
   output logic [2:0]                         rsp_result_code,
   output logic [15:0]                        rsp_cookie_out,
   output logic                               rsp_queue_stopped,
   output logic [5:0]                         rsp_free_slot_count,
   output logic [15:0]                        rsp_bytes_in_use_out,
   // Configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [txcm_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [txcm_pkg::DATA_W-1:0]   pwdata,
   output logic      [txcm_pkg::DATA_W-1:0]   prdata,
   output logic                               pready
);
   import txcm_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Registers: buffer size, header length, queue number
   txcm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencing: clearing pass, then load / commit per transaction
   txcm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Slot stack, byte credit and result registers
   txcm_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .cfg                  (cfg),
      .req_op               (req_op),
      .req_frame_length     (req_frame_length),
      .req_status_cookie    (req_status_cookie),
      .rsp_strobe           (rsp_strobe),
      .rsp_result_code      (rsp_result_code),
      .rsp_cookie_out       (rsp_cookie_out),
      .rsp_queue_stopped    (rsp_queue_stopped),
      .rsp_free_slot_count  (rsp_free_slot_count),
      .rsp_bytes_in_use_out (rsp_bytes_in_use_out)
   );

endmodule

`default_nettype wire

FILE: hdl/txcm_checker.sv
// Port-level checks for the transmit slot and byte credit manager, bound to
// the top level. Depends on txcm_pkg.
`default_nettype none

module txcm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [2:0]  rsp_result_code,
   input wire logic [15:0] rsp_cookie_out,
   input wire logic        rsp_queue_stopped
);
   import txcm_pkg::*;

   // Every result traces back to an accepted transaction
   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without an accepted transaction");

   // An accepted transaction holds the command channel for its execute cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // Results never come back to back
   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   // Only a granted slot carries a cookie
   a_cookie_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_code != RC_OK) |-> (rsp_cookie_out == 16'd0))
      else $error("nonzero cookie on a refused transaction");

   // A no-room refusal always leaves the queue stopped
   a_no_room_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_code == RC_NO_ROOM) |-> rsp_queue_stopped)
      else $error("no-room refusal without stopped");

endmodule

bind tx_slot_and_byte_credit_manager_unit txcm_checker u_txcm_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_result_code   (rsp_result_code),
   .rsp_cookie_out    (rsp_cookie_out),
   .rsp_queue_stopped (rsp_queue_stopped)
);

`default_nettype wire
